>>> hdl/des_cbc_cipher_defines.svh
// Assertion macros shared by the cipher RTL.
`ifndef DES_CBC_CIPHER_DEFINES_SVH
`define DES_CBC_CIPHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/dcc_pkg.sv
`timescale 1ns / 1ps
package dcc_pkg;

	localparam int ROUNDS = 16;
	localparam int HALF_KEY_BITS = 28;

	typedef enum logic [1:0] {
		REG_KEY = 2'd0,
		REG_IV  = 2'd1,
		REG_DIR = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	typedef logic [47:0] subkey_t;

	localparam logic [6:0] IP_TAB [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

	localparam logic [6:0] FP_TAB [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

	localparam logic [5:0] E_TAB [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
		28,29,30,31,32,1 };

	localparam logic [5:0] P_TAB [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

	localparam logic [6:0] PC1_TAB [56] = '{
		57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
		10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
		63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };

	localparam logic [5:0] PC2_TAB [48] = '{
		14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
		46,42,50,36,29,32 };

	// Total left rotation of each key half after each round.
	localparam logic [4:0] ROT_SUM [ROUNDS] = '{
		1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28 };

	localparam logic [3:0] SBOX [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

	function automatic logic [63:0] perm_ip(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_TAB[i])];
		return r;
	endfunction

	function automatic logic [63:0] perm_fp(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_TAB[i])];
		return r;
	endfunction

	function automatic logic [55:0] perm_pc1(input logic [63:0] v);
		logic [55:0] r;
		for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(PC1_TAB[i])];
		return r;
	endfunction

	function automatic logic [47:0] perm_pc2(input logic [55:0] v);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(PC2_TAB[i])];
		return r;
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] v, input subkey_t k);
		logic [47:0] x;
		logic [5:0] six;
		logic [31:0] s;
		logic [31:0] r;
		for (int i = 0; i < 48; i++) x[47-i] = v[32-int'(E_TAB[i])];
		x = x ^ k;
		for (int b = 0; b < 8; b++) begin
			six = x[47-6*b -: 6];
			s[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) r[31-i] = s[32-int'(P_TAB[i])];
		return r;
	endfunction

endpackage

>>> hdl/des_cbc_cipher.sv
`timescale 1ns / 1ps
// An accepted request goes to the input register, then its result to the output register.
// Throughput: one request per cycle unless the output stalls; all sixteen rounds and
// the chaining XOR are one combinational pass between the input and result registers.
// Reset clears key, vector, direction and valid flags; the chaining value starts at zero.
`include "des_cbc_cipher_defines.svh"
module des_cbc_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // data_block[63:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // result_block[63:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [63:0] key_q;
	logic [63:0] iv_q;
	logic        dir_q;
	logic [63:0] chain_q;
	logic        valid_s1;
	logic [63:0] data_s1;
	logic        out_valid_q;
	logic [63:0] result_q;
	logic        cfg_wr;
	logic        advance;
	dcc_pkg::reg_idx_t idx;
	dcc_pkg::subkey_t  subkeys [dcc_pkg::ROUNDS];
	logic [31:0] l_w [dcc_pkg::ROUNDS+1];
	logic [31:0] r_w [dcc_pkg::ROUNDS+1];
	logic [63:0] ip_out;
	logic [63:0] des_out;
	logic [63:0] result_d;

	assign pready = 1'b1;
	assign idx = dcc_pkg::reg_idx_t'(paddr[4:3]);
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (idx)
			dcc_pkg::REG_KEY: prdata = key_q;
			dcc_pkg::REG_IV:  prdata = iv_q;
			dcc_pkg::REG_DIR: prdata = {63'd0, dir_q};
			default:          prdata = 64'd0;
		endcase
	end

	dcc_key_sched u_keys (
		.cipher_key(key_q),
		.subkeys(subkeys)
	);

	assign ip_out = dcc_pkg::perm_ip(dir_q ? data_s1 : (data_s1 ^ chain_q));
	assign l_w[0] = ip_out[63:32];
	assign r_w[0] = ip_out[31:0];

	for (genvar i = 0; i < dcc_pkg::ROUNDS; i++) begin : g_round
		dcc_round u_round (
			.l_in(l_w[i]),
			.r_in(r_w[i]),
			.k(dir_q ? subkeys[dcc_pkg::ROUNDS-1-i] : subkeys[i]),
			.l_out(l_w[i+1]),
			.r_out(r_w[i+1])
		);
	end

	assign des_out = dcc_pkg::perm_fp({r_w[dcc_pkg::ROUNDS], l_w[dcc_pkg::ROUNDS]});
	assign result_d = dir_q ? (des_out ^ chain_q) : des_out;

	assign advance = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= 64'd0;
			iv_q <= 64'd0;
			dir_q <= 1'b0;
			chain_q <= 64'd0;
		end else if (cfg_wr) begin
			case (idx)
				dcc_pkg::REG_KEY: begin
					key_q <= pwdata;
					chain_q <= iv_q;
				end
				dcc_pkg::REG_IV: begin
					iv_q <= pwdata;
					chain_q <= pwdata;
				end
				dcc_pkg::REG_DIR: begin
					dir_q <= pwdata[0];
					chain_q <= iv_q;
				end
				default: begin
				end
			endcase
		end else if (valid_s1 && advance) begin
			chain_q <= dir_q ? data_s1 : result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) data_s1 <= s_tdata;
		if (valid_s1 && advance) result_q <= result_d;
	end

	`DCC_ASSERT_NEXT(a_stage_moves, clk, arst_n, valid_s1 && advance, out_valid_q, "result lost")
	`DCC_ASSERT_SAME(a_ready_block, clk, arst_n, !s_tready, valid_s1 && out_valid_q, "bad stall")
	`DCC_ASSERT_NEXT(a_iv_reload, clk, arst_n, cfg_wr && idx != dcc_pkg::REG_NONE,
		chain_q == iv_q, "chain not reloaded")
	`DCC_ASSERT_NEXT(a_dec_chain, clk, arst_n, valid_s1 && advance && dir_q && !cfg_wr,
		chain_q == $past(data_s1), "decrypt chain wrong")

endmodule

>>> hdl/dcc_key_sched.sv
`timescale 1ns / 1ps
module dcc_key_sched (
	input  logic [63:0]      cipher_key,
	output dcc_pkg::subkey_t subkeys [dcc_pkg::ROUNDS]
);

	logic [55:0] k56;
	logic [27:0] c0;
	logic [27:0] d0;

	assign k56 = dcc_pkg::perm_pc1(cipher_key);
	assign c0 = k56[55:28];
	assign d0 = k56[27:0];

	for (genvar i = 0; i < dcc_pkg::ROUNDS; i++) begin : g_key
		localparam int S = int'(dcc_pkg::ROT_SUM[i]);
		logic [27:0] c;
		logic [27:0] d;
		if (S == dcc_pkg::HALF_KEY_BITS) begin : g_full
			assign c = c0;
			assign d = d0;
		end else begin : g_rot
			assign c = {c0[27-S:0], c0[27:28-S]};
			assign d = {d0[27-S:0], d0[27:28-S]};
		end
		assign subkeys[i] = dcc_pkg::perm_pc2({c, d});
	end

endmodule

>>> hdl/dcc_round.sv
`timescale 1ns / 1ps
module dcc_round (
	input  logic [31:0]      l_in,
	input  logic [31:0]      r_in,
	input  dcc_pkg::subkey_t k,
	output logic [31:0]      l_out,
	output logic [31:0]      r_out
);

	assign l_out = r_in;
	assign r_out = l_in ^ dcc_pkg::feistel(r_in, k);

endmodule

>>> dv/des_cbc_cipher_tb.sv
`timescale 1ns / 1ps
module des_cbc_cipher_tb;

	// Tracks key, vector, direction and chaining value, and queues the
	// block that each accepted request must produce.
	class cbc_scoreboard;
		bit [63:0] key_q;
		bit [63:0] iv_q;
		bit        dir_q;
		bit [63:0] chain_q;
		bit [47:0] round_keys [dcc_pkg::ROUNDS];
		bit [63:0] pending_blocks [$];
		int        errors;

		function new();
			key_q = '0;
			iv_q = '0;
			dir_q = 1'b0;
			chain_q = '0;
			errors = 0;
			derive_keys();
		endfunction

		function void derive_keys();
			bit [55:0] k56;
			bit [27:0] c;
			bit [27:0] d;
			bit [55:0] cd;
			int        shifts [dcc_pkg::ROUNDS] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
			for (int i = 0; i < 56; i++)
				k56[55-i] = key_q[64-int'(dcc_pkg::PC1_TAB[i])];
			c = k56[55:28];
			d = k56[27:0];
			for (int r = 0; r < dcc_pkg::ROUNDS; r++) begin
				repeat (shifts[r]) begin
					c = {c[26:0], c[27]};
					d = {d[26:0], d[27]};
				end
				cd = {c, d};
				for (int i = 0; i < 48; i++)
					round_keys[r][47-i] = cd[56-int'(dcc_pkg::PC2_TAB[i])];
			end
		endfunction

		function bit [31:0] round_func(bit [31:0] v, bit [47:0] k);
			bit [47:0] x;
			bit [5:0]  six;
			bit [31:0] s;
			bit [31:0] p;
			for (int i = 0; i < 48; i++) x[47-i] = v[32-int'(dcc_pkg::E_TAB[i])];
			x ^= k;
			for (int b = 0; b < 8; b++) begin
				six = x[47-6*b -: 6];
				s[31-4*b -: 4] = dcc_pkg::SBOX[b][{six[5], six[0]} * 16 + six[4:1]];
			end
			for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(dcc_pkg::P_TAB[i])];
			return p;
		endfunction

		function bit [63:0] run_rounds(bit [63:0] blk, bit rev);
			bit [63:0] v;
			bit [63:0] o;
			bit [31:0] l;
			bit [31:0] r;
			bit [31:0] t;
			for (int i = 0; i < 64; i++) v[63-i] = blk[64-int'(dcc_pkg::IP_TAB[i])];
			l = v[63:32];
			r = v[31:0];
			for (int i = 0; i < dcc_pkg::ROUNDS; i++) begin
				t = r;
				r = l ^ round_func(r, round_keys[rev ? dcc_pkg::ROUNDS-1-i : i]);
				l = t;
			end
			v = {r, l};
			for (int i = 0; i < 64; i++) o[63-i] = v[64-int'(dcc_pkg::FP_TAB[i])];
			return o;
		endfunction

		function void write_reg(dcc_pkg::reg_idx_t idx, bit [63:0] val);
			case (idx)
				dcc_pkg::REG_KEY: begin
					key_q = val;
					derive_keys();
				end
				dcc_pkg::REG_IV: iv_q = val;
				dcc_pkg::REG_DIR: dir_q = val[0];
				default: return;
			endcase
			chain_q = iv_q;
		endfunction

		function void note_request(bit [63:0] blk);
			bit [63:0] res;
			if (!dir_q) begin
				res = run_rounds(blk ^ chain_q, 1'b0);
				chain_q = res;
			end else begin
				res = run_rounds(blk, 1'b1) ^ chain_q;
				chain_q = blk;
			end
			pending_blocks = {pending_blocks, res};
		endfunction

		function void check_result(bit [63:0] got);
			bit [63:0] want;
			if (pending_blocks.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending_blocks.pop_front();
			if (got !== want) begin
				$display("%0t: result_block expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	cbc_scoreboard sb = new();
	bit  hold_req;
	bit  no_idle;
	int  idle_cycles = 0;

	des_cbc_cipher i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int pick_gap();
		if (no_idle || $urandom_range(0, 99) < 60) return 0;
		if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic apb_write(dcc_pkg::reg_idx_t idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic send_block(logic [63:0] blk);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= blk;
		do @(posedge clk); while (!s_tready);
		sb.note_request(blk);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_blocks.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Receiver: random back-pressure plus one long hold-off on request.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				m_tready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 20000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		dcc_pkg::reg_idx_t idx;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 1'b0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: zero key and vector, encrypting.
		send_block('0);
		send_block('1);
		send_block(64'h0123456789ABCDEF);
		drain();
		apb_write(dcc_pkg::REG_KEY, 64'h133457799BBCDFF1);
		send_block(64'h0123456789ABCDEF);
		send_block(64'h0123456789ABCDEF);
		drain();
		// Parity bits flipped must give the same chain.
		apb_write(dcc_pkg::REG_KEY, 64'h133457799BBCDFF1 ^ 64'h0101010101010101);
		send_block(64'h0123456789ABCDEF);
		drain();
		// An unmapped address leaves the chaining value alone.
		apb_write(dcc_pkg::REG_NONE, '1);
		send_block('1);
		drain();
		// Rewriting the same value reloads the chain from the vector.
		apb_write(dcc_pkg::REG_IV, 64'hFFFFFFFFFFFFFFFF);
		apb_write(dcc_pkg::REG_IV, 64'hFFFFFFFFFFFFFFFF);
		send_block('0);
		send_block('1);
		drain();
		apb_write(dcc_pkg::REG_DIR, 64'hFFFFFFFFFFFFFFFE);
		send_block('0);
		drain();
		apb_write(dcc_pkg::REG_DIR, 64'd3);
		apb_write(dcc_pkg::REG_KEY, '1);
		send_block('0);
		send_block('1);
		send_block(64'h8000000000000001);
		drain();
		apb_write(dcc_pkg::REG_KEY, '0);
		apb_write(dcc_pkg::REG_IV, '0);
		send_block(64'h8000000000000001);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			no_idle = (ph % 4 == 1);
			for (int w = 0; w < 3; w++) begin
				idx = dcc_pkg::reg_idx_t'($urandom_range(0, 3));
				apb_write(idx, pick_word());
			end
			apb_write(dcc_pkg::REG_DIR, {$urandom, $urandom});
			if (ph == 3) hold_req = 1'b1;
			for (int n = 0; n < 112; n++) send_block(pick_word());
			drain();
		end

		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
